[rtl/mpd_pkg.sv]
package mpd_pkg;

    localparam int NUM_HOSTS = 4;
    localparam int MAX_FRAME = 2048;
    localparam int REPEATS   = 16;

    localparam int HOST_REGS = 4;
    localparam int MAC_LEN   = 6;
    localparam int HDR_LEN   = 14;
    localparam int WIN_LEN   = (REPEATS + 1) * MAC_LEN;
    localparam int POS_W     = $clog2(MAX_FRAME + 1);
    localparam int MAC_W     = 8 * MAC_LEN;
    localparam int HOST_W    = 2;
    localparam int COUNT_W   = 3;
    localparam int CFG_IDX_W = 3;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOST_MAC_A  = 3'd0,
        CFG_HOST_MAC_B  = 3'd1,
        CFG_HOST_MAC_C  = 3'd2,
        CFG_HOST_MAC_D  = 3'd3,
        CFG_HOST_COUNT  = 3'd4
    } cfg_index_t;

    typedef logic [NUM_HOSTS-1:0][7:0] host_bytes_t;
    typedef logic [NUM_HOSTS-1:0]      host_flags_t;
    typedef logic [MAC_W-1:0]          mac_t;
    typedef mac_t [HOST_REGS-1:0]      mac_table_t;

endpackage

[rtl/magic_packet_detector_unit.sv]
// Result: the frame's last word is held in the pending stage, and the result word is registered
// from it once any earlier result word has been taken by m_tready.
// Throughput: one frame word per cycle while s_tready is high; the 102-cell byte window shifts
// one byte per accepted word past the header, and each cell registers its match flags.
// Reset: aresetn is synchronous and active low; it clears the host registers, frame state
// and handshake state. The window cells are not reset, since a frame refills them first.
module magic_packet_detector_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // frame_byte[7:0]
    input  logic                           s_tlast,   // frame_end
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [7:0]                     m_tdata,   // wake_found, host_index[1:0], zeros
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mpd_pkg::MAC_W-1:0]      cfg_data
);
    import mpd_pkg::*;

    mac_table_t           mac_reg, mac_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic                 bcast_reg, bcast_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic                 pend_end_reg, pend_end_next;
    logic                 pend_test_reg, pend_test_next;
    logic                 latch_reg, latch_next;
    logic [HOST_W-1:0]    host_reg, host_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_found_reg, out_found_next;
    logic [HOST_W-1:0]    out_idx_reg, out_idx_next;

    logic                 accept;
    logic                 stall;
    logic                 live;
    logic                 shift_en;
    logic                 bcast_upd;
    logic                 test_en;
    host_flags_t          hit;
    host_flags_t          hit_en;
    logic                 hit_any;
    logic [HOST_W-1:0]    hit_idx;
    logic                 found;
    logic [HOST_W-1:0]    found_idx;

    mpd_window u_window (
        .aclk     (aclk),
        .shift_en (shift_en),
        .din      (s_tdata),
        .host_mac (mac_reg),
        .hit      (hit)
    );

    assign stall     = pend_valid_reg & pend_end_reg & out_valid_reg & ~m_tready;
    assign s_tready  = ~stall;
    assign accept    = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;
    assign live      = (pos_reg < POS_W'(MAX_FRAME));
    assign shift_en  = accept & live & (pos_reg >= POS_W'(HDR_LEN));
    assign bcast_upd = bcast_reg &
                       ~(live & (pos_reg < POS_W'(MAC_LEN)) & (s_tdata != SYNC_BYTE));
    assign test_en   = live & bcast_upd & (pos_reg >= POS_W'(HDR_LEN + WIN_LEN - 1));

    always_comb begin
        hit_idx = '0;
        for (int h = 0; h < NUM_HOSTS; h++) begin
            hit_en[h] = hit[h] & (COUNT_W'(h) < count_reg);
        end
        for (int h = NUM_HOSTS - 1; h >= 0; h--) begin
            if (hit_en[h]) begin
                hit_idx = HOST_W'(h);
            end
        end
        hit_any = pend_test_reg & (|hit_en);
    end

    assign found     = latch_reg | hit_any;
    assign found_idx = latch_reg ? host_reg : (hit_any ? hit_idx : '0);

    always_comb begin
        mac_next        = mac_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        bcast_next      = bcast_reg;
        pend_valid_next = pend_valid_reg;
        pend_end_next   = pend_end_reg;
        pend_test_next  = pend_test_reg;
        latch_next      = latch_reg;
        host_next       = host_reg;
        out_valid_next  = out_valid_reg;
        out_found_next  = out_found_reg;
        out_idx_next    = out_idx_reg;

        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_HOST_MAC_A: mac_next[0] = cfg_data;
                CFG_HOST_MAC_B: mac_next[1] = cfg_data;
                CFG_HOST_MAC_C: mac_next[2] = cfg_data;
                CFG_HOST_MAC_D: mac_next[3] = cfg_data;
                CFG_HOST_COUNT: count_next  = cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        if (!stall) begin
            if (pend_valid_reg) begin
                if (pend_end_reg) begin
                    out_valid_next = 1'b1;
                    out_found_next = found;
                    out_idx_next   = found_idx;
                    latch_next     = 1'b0;
                    host_next      = '0;
                end else if (!latch_reg && hit_any) begin
                    latch_next = 1'b1;
                    host_next  = hit_idx;
                end
            end
            pend_valid_next = accept;
        end

        if (accept) begin
            pend_end_next  = s_tlast;
            pend_test_next = test_en;
            if (s_tlast) begin
                pos_next   = '0;
                bcast_next = 1'b1;
            end else begin
                bcast_next = bcast_upd;
                if (live) begin
                    pos_next = pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mac_reg        <= '0;
            count_reg      <= '0;
            pos_reg        <= '0;
            bcast_reg      <= 1'b1;
            pend_valid_reg <= 1'b0;
            pend_end_reg   <= 1'b0;
            pend_test_reg  <= 1'b0;
            latch_reg      <= 1'b0;
            host_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_found_reg  <= 1'b0;
            out_idx_reg    <= '0;
        end else begin
            mac_reg        <= mac_next;
            count_reg      <= count_next;
            pos_reg        <= pos_next;
            bcast_reg      <= bcast_next;
            pend_valid_reg <= pend_valid_next;
            pend_end_reg   <= pend_end_next;
            pend_test_reg  <= pend_test_next;
            latch_reg      <= latch_next;
            host_reg       <= host_next;
            out_valid_reg  <= out_valid_next;
            out_found_reg  <= out_found_next;
            out_idx_reg    <= out_idx_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_idx_reg, out_found_reg};

    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_found_reg) |-> (out_idx_reg == '0))
        else $error("host index nonzero on a word without a wake hit");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_W'(MAX_FRAME))
        else $error("byte position ran past the frame limit");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(pend_valid_reg && pend_end_reg))
        else $error("result word issued without a frame end");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_valid_reg && pend_test_reg) |-> (pos_reg == '0 || !pend_end_reg
            || pos_reg <= POS_W'(MAX_FRAME)))
        else $error("pattern test pending in an inconsistent frame state");

endmodule

[rtl/mpd_cell.sv]
module mpd_cell (
    input  logic                 aclk,
    input  logic                 shift_en,
    input  logic [7:0]           din,
    input  mpd_pkg::host_bytes_t expect_bytes,
    output logic [7:0]           dout,
    output mpd_pkg::host_flags_t match
);
    import mpd_pkg::*;

    logic [7:0]  byte_reg;
    host_flags_t match_reg;
    host_flags_t match_next;

    always_comb begin
        for (int h = 0; h < NUM_HOSTS; h++) begin
            match_next[h] = (din == expect_bytes[h]);
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg  <= din;
            match_reg <= match_next;
        end
    end

    assign dout  = byte_reg;
    assign match = match_reg;

endmodule

[rtl/mpd_window.sv]
module mpd_window (
    input  logic                aclk,
    input  logic                shift_en,
    input  logic [7:0]          din,
    input  mpd_pkg::mac_table_t host_mac,
    output mpd_pkg::host_flags_t hit
);
    import mpd_pkg::*;

    logic [7:0]     chain [WIN_LEN+1];
    host_flags_t    flags [WIN_LEN];
    host_bytes_t    expect_bytes [WIN_LEN];
    logic [WIN_LEN-1:0] column [NUM_HOSTS];

    assign chain[WIN_LEN] = din;

    for (genvar k = 0; k < WIN_LEN; k++) begin : g_cell
        for (genvar h = 0; h < NUM_HOSTS; h++) begin : g_exp
            if (k < MAC_LEN) begin : g_sync
                assign expect_bytes[k][h] = SYNC_BYTE;
            end else begin : g_mac
                assign expect_bytes[k][h] =
                    host_mac[h][8*(MAC_LEN-1-((k-MAC_LEN)%MAC_LEN)) +: 8];
            end
            assign column[h][k] = flags[k][h];
        end

        mpd_cell u_cell (
            .aclk         (aclk),
            .shift_en     (shift_en),
            .din          (chain[k+1]),
            .expect_bytes (expect_bytes[k]),
            .dout         (chain[k]),
            .match        (flags[k])
        );
    end

    for (genvar h = 0; h < NUM_HOSTS; h++) begin : g_hit
        assign hit[h] = &column[h];
    end

endmodule
